// ----- hw/rtl/fbfa_pkg.sv -----
package fbfa_pkg;

	localparam int unsigned SLOT_W = 3;
	localparam int unsigned CAP_W  = 16;
	localparam int unsigned RND_W  = 17;
	// wide enough for the largest supported block count
	localparam int unsigned PICK_W = 6;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	localparam logic MODE_FIRST_FIT = 1'b0;
	localparam logic MODE_BEST_FIT  = 1'b1;

	typedef struct packed {
		logic              command;
		logic [SLOT_W-1:0] block_slot;
		logic [CAP_W-1:0]  amount;
	} in_word_t;

	typedef struct packed {
		logic              granted;
		logic [SLOT_W-1:0] chosen_block;
		logic [RND_W-1:0]  rounded_amount;
		logic [CAP_W-1:0]  remaining_after;
	} out_word_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic              valid;
		logic [RND_W-1:0]  rounded;
		logic              found;
		logic [PICK_W-1:0] pick;
		logic [CAP_W-1:0]  best_left;
	} token_t;

	// capacity write into one cell
	typedef struct packed {
		logic             en;
		logic [CAP_W-1:0] data;
	} cap_wr_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

// ----- hw/rtl/fbfa_cell.sv -----
module fbfa_cell #(
	parameter logic [fbfa_pkg::PICK_W-1:0] CELL_IDX = '0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fit_mode,
	input  fbfa_pkg::cap_wr_t wr,
	input  fbfa_pkg::token_t  tok_in,
	output fbfa_pkg::token_t  tok_out
);
	import fbfa_pkg::*;

	logic [CAP_W-1:0] cap_q;
	token_t           tok_q;
	token_t           tok_nxt;
	logic             fits;
	logic             take;
	logic [CAP_W-1:0] left;

	always_comb begin
		fits = tok_in.rounded < {1'b0, cap_q};
		// rounded is below cap whenever left is used, so it fits in CAP_W bits
		left = cap_q - tok_in.rounded[CAP_W-1:0];
		take = fits && (!tok_in.found ||
			(fit_mode == MODE_BEST_FIT && left < tok_in.best_left));
		tok_nxt = tok_in;
		if (take) begin
			tok_nxt.found     = 1'b1;
			tok_nxt.pick      = CELL_IDX;
			tok_nxt.best_left = left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (wr.en) begin
			cap_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

// ----- hw/rtl/first_or_best_fit_allocator_top.sv -----
// first-fit / best-fit block allocator
// input channel in_valid/in_ready/in_data: a word either loads the capacity
//   of one block (command load, no result) or asks for an allocation
//   (command alloc, exactly one result word)
// output channel out_valid/out_ready/out_data: one word per allocation with
//   grant flag, chosen block, size rounded up to a multiple of four and the
//   capacity left in that block
// cfg_wr_en/cfg_wr_data set the placement policy, first fit or best fit
// each block's capacity lives in its own cell; a request token walks the row
//   of cells one cell per cycle, the first cell working in the acceptance
//   cycle, and the last token is registered into the output register
//   on the next edge, which raises out_valid
// one request is in flight at a time: in_ready is low while the token walks,
//   so the next word waits for the token to exit; a load holds up nothing
// when the receiver stalls, the result word holds in the output register and
//   no new word is taken until it is delivered (or taken the same cycle)
// reset clears all capacities to zero, selects first fit and empties the
//   output register
module first_or_best_fit_allocator_top #(
	parameter int unsigned NUM_BLOCKS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  fbfa_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output fbfa_pkg::out_word_t out_data
);
	import fbfa_pkg::*;

	state_t    state_q;
	state_t    state_nxt;
	logic      fit_mode_q;
	logic      out_valid_q;
	out_word_t out_q;

	logic      accept;
	logic      load_now;
	logic      charge_now;
	token_t    tok [NUM_BLOCKS+1];
	token_t    last_tok;
	cap_wr_t   cell_wr [NUM_BLOCKS];
	logic [RND_W-1:0] rounded;

	// policy register; the user must write it only while the block is idle, the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= MODE_FIRST_FIT;
		end else if (cfg_wr_en) begin
			fit_mode_q <= cfg_wr_data;
		end
	end

	assign accept   = in_valid && in_ready;
	assign last_tok = tok[NUM_BLOCKS];
	// result leaves the chain: charge the winning cell
	assign charge_now = last_tok.valid && last_tok.found;
	assign load_now   = accept && in_data.command == CMD_LOAD;

	// round up to a multiple of four
	assign rounded = ({1'b0, in_data.amount} + RND_W'(3)) & ~RND_W'(3);

	// token entering the first cell
	always_comb begin
		tok[0]           = '0;
		tok[0].valid     = accept && in_data.command == CMD_ALLOC;
		tok[0].rounded   = rounded;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_data.command == CMD_ALLOC) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_tok.valid) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		case (state_q)
			ST_IDLE: in_ready = !out_valid_q || out_ready;
			ST_SCAN: in_ready = 1'b0;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (last_tok.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// an unfound token carries zero pick and zero leftover
	always_ff @(posedge clk) begin
		if (last_tok.valid) begin
			out_q.granted         <= last_tok.found;
			out_q.chosen_block    <= last_tok.pick[SLOT_W-1:0];
			out_q.rounded_amount  <= last_tok.rounded;
			out_q.remaining_after <= last_tok.best_left;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// row of cells, one per block
	for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
		// blocks at index 8 and up can never be addressed by a load
		always_comb begin
			cell_wr[i].en   = (load_now &&
				{{(PICK_W-SLOT_W){1'b0}}, in_data.block_slot} == PICK_W'(i)) ||
				(charge_now && last_tok.pick == PICK_W'(i));
			cell_wr[i].data = charge_now ? last_tok.best_left : in_data.amount;
		end

		fbfa_cell #(
			.CELL_IDX(PICK_W'(i))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.fit_mode (fit_mode_q),
			.wr       (cell_wr[i]),
			.tok_in   (tok[i]),
			.tok_out  (tok[i+1])
		);
	end

endmodule

// ----- tb/sv/first_or_best_fit_allocator_top_tb.sv -----
module first_or_best_fit_allocator_top_tb;
	import fbfa_pkg::*;

	localparam int unsigned NBLK = 8;
	// a request walks all cells and then registers its result, plus some margin
	localparam int unsigned SETTLE = NBLK + 4;
	// cycles with no handshake or register write before the run is declared hung
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned RANDOM_WORDS = 1500;
	localparam int unsigned DIRECTED_WORDS = 21;

	// mirror of the capacity table and the placement policy; every accepted
	// request word leaves one expected grant word in the queue
	class alloc_ledger;
		logic             fit_mode;
		logic [CAP_W-1:0] cap_left [NBLK];
		out_word_t        grants_due [$];
		int unsigned      loads, requests, grants, misses, bad;

		function new();
			fit_mode = MODE_FIRST_FIT;
			foreach (cap_left[i]) cap_left[i] = '0;
			loads = 0;
			requests = 0;
			grants = 0;
			misses = 0;
			bad = 0;
		endfunction

		function void set_mode(logic m);
			fit_mode = m;
		endfunction

		function int unsigned pending();
			return grants_due.size();
		endfunction

		// apply one accepted input word to the table
		function void note_word(in_word_t w);
			logic [RND_W-1:0] rnd;
			logic [CAP_W-1:0] left, best_left;
			int unsigned      pick, b;
			bit               found;
			out_word_t        e;
			if (w.command == CMD_LOAD) begin
				if (w.block_slot < NBLK) cap_left[w.block_slot] = w.amount;
				loads++;
				return;
			end
			requests++;
			rnd = ({1'b0, w.amount} + 17'd3) & ~17'd3;
			found = 1'b0;
			pick = 0;
			best_left = '0;
			for (b = 0; b < NBLK; b++) begin
				// strictly greater capacity is needed to fit
				if (rnd < {1'b0, cap_left[b]}) begin
					left = cap_left[b] - rnd[CAP_W-1:0];
					if (!found || (fit_mode == MODE_BEST_FIT && left < best_left)) begin
						found = 1'b1;
						pick = b;
						best_left = left;
					end
					if (fit_mode == MODE_FIRST_FIT) break;
				end
			end
			e.granted = found;
			e.rounded_amount = rnd;
			if (found) begin
				cap_left[pick] = best_left;
				e.chosen_block = SLOT_W'(pick);
				e.remaining_after = best_left;
				grants++;
			end else begin
				e.chosen_block = '0;
				e.remaining_after = '0;
				misses++;
			end
			grants_due.push_back(e);
		endfunction

		// compare one delivered result word with the oldest expectation
		function void check_word(out_word_t got);
			out_word_t want;
			if (grants_due.size() == 0) begin
				bad++;
				if (bad <= 10)
					$display("unexpected result word: granted=%0d block=%0d rounded=%0d left=%0d",
						got.granted, got.chosen_block, got.rounded_amount, got.remaining_after);
				return;
			end
			want = grants_due.pop_front();
			if (got.granted !== want.granted || got.chosen_block !== want.chosen_block ||
					got.rounded_amount !== want.rounded_amount ||
					got.remaining_after !== want.remaining_after) begin
				bad++;
				if (bad <= 10) begin
					$display("result mismatch: expected granted=%0d block=%0d rounded=%0d left=%0d",
						want.granted, want.chosen_block, want.rounded_amount, want.remaining_after);
					$display("                 got      granted=%0d block=%0d rounded=%0d left=%0d",
						got.granted, got.chosen_block, got.rounded_amount, got.remaining_after);
				end
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      cfg_wr_en;
	logic      cfg_wr_data;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;

	alloc_ledger ledger;
	int unsigned idle_cycles = 0;
	int unsigned words_sent = 0;
	int unsigned mode_writes = 0;

	first_or_best_fit_allocator_top #(
		.NUM_BLOCKS(NBLK)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	// 10 unit period, low first
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// both handshakes are sampled on pre-edge values; all drivers use nba
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) ledger.note_word(in_data);
			if (out_valid && out_ready) ledger.check_word(out_data);
		end
	end

	// watchdog: any handshake or register write counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
				idle_cycles = 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", idle_cycles);
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles = idle_cycles + 1;
			end
		end
	end

	// receiver: switches at random between stall patterns, each held for a random stretch
	// always ready, coin flip, one cycle in five, and long runs high or low
	initial begin : receiver
		int unsigned pattern, hold, run_left, tick;
		logic        level;
		pattern = 0;
		hold = 0;
		run_left = 0;
		tick = 0;
		level = 1'b1;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold == 0) begin
				pattern = $urandom_range(0, 3);
				hold = $urandom_range(40, 240);
			end
			hold--;
			tick++;
			case (pattern)
				0: begin
					out_ready <= 1'b1;
				end
				1: begin
					out_ready <= 1'($urandom_range(0, 1));
				end
				2: begin
					out_ready <= (tick % 5 == 0);
				end
				default: begin
					if (run_left == 0) begin
						level = ~level;
						run_left = $urandom_range(1, 25);
					end
					run_left--;
					out_ready <= level;
				end
			endcase
		end
	end

	// present one word and hold it until the edge that accepts it;
	// called at a rising edge, returns at the accepting edge
	task automatic send_word(input logic cmd, input logic [SLOT_W-1:0] slot,
			input logic [CAP_W-1:0] amt);
		in_word_t w;
		w.command = cmd;
		w.block_slot = slot;
		w.amount = amt;
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
	endtask

	// sender gap; zero keeps valid high for a back-to-back word
	task automatic sender_gap(input int unsigned gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait for every expected result, then let any trailing load finish
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		// let the monitor log the last accepted word before checking the queue
		@(posedge clk);
		while (ledger.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// policy write, only while the block is idle
	task automatic write_mode(input logic m);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		ledger.set_mode(m);
		mode_writes++;
	endtask

	task automatic load_random_capacity(input logic [SLOT_W-1:0] slot);
		logic [CAP_W-1:0] amt;
		case ($urandom_range(0, 9))
			0: amt = '0;
			1: amt = '1;
			2, 3: amt = CAP_W'($urandom);
			default: amt = CAP_W'($urandom_range(1, 4000));
		endcase
		send_word(CMD_LOAD, slot, amt);
	endtask

	// one random word: mostly requests, many sized against what the table holds
	task automatic send_random();
		int unsigned      r;
		logic [CAP_W-1:0] amt, c;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			load_random_capacity(SLOT_W'($urandom_range(0, 7)));
		end else begin
			c = ledger.cap_left[SLOT_W'($urandom_range(0, NBLK - 1))];
			r = $urandom_range(0, 19);
			if (r < 8) begin
				// at or just under some block's capacity
				amt = (c > 6) ? CAP_W'(c - $urandom_range(0, 6)) :
					CAP_W'($urandom_range(0, 6));
			end else if (r < 14) begin
				amt = CAP_W'($urandom_range(0, 256));
			end else if (r < 17) begin
				amt = CAP_W'($urandom);
			end else if (r < 19) begin
				amt = CAP_W'(c / 2 + $urandom_range(0, 8));
			end else begin
				// rounds to 65536 and can never fit
				amt = CAP_W'($urandom_range(65533, 65535));
			end
			send_word(CMD_ALLOC, '0, amt);
		end
	endtask

	initial begin : stimulus
		int unsigned phase_len, burst_left, k, s;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		ledger = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, first fit
		write_mode(MODE_FIRST_FIT);
		// empty table: even a zero request has no fit
		send_word(CMD_ALLOC, '0, 16'd0);
		send_word(CMD_LOAD, 3'd0, 16'd65535);
		send_word(CMD_LOAD, 3'd1, 16'd100);
		send_word(CMD_LOAD, 3'd2, 16'd40);
		send_word(CMD_LOAD, 3'd3, 16'd40);
		send_word(CMD_LOAD, 3'd4, 16'd12);
		send_word(CMD_LOAD, 3'd5, 16'd1000);
		send_word(CMD_LOAD, 3'd6, 16'd7);
		send_word(CMD_LOAD, 3'd7, 16'd0);
		// large requests round to 65536 and never fit
		send_word(CMD_ALLOC, '1, 16'd65535);
		send_word(CMD_ALLOC, '0, 16'd65533);
		// zero request charges nothing
		send_word(CMD_ALLOC, '0, 16'd0);
		send_word(CMD_ALLOC, '0, 16'd65532);
		send_word(CMD_ALLOC, '0, 16'd1);
		// capacity equal to the size does not fit
		send_word(CMD_ALLOC, '0, 16'd96);

		// directed, best fit
		drain_and_settle();
		write_mode(MODE_BEST_FIT);
		// tie between two blocks, lowest index wins
		send_word(CMD_ALLOC, '0, 16'd33);
		send_word(CMD_ALLOC, '0, 16'd2);
		send_word(CMD_ALLOC, '0, 16'd0);
		send_word(CMD_LOAD, 3'd7, 16'd65535);
		send_word(CMD_ALLOC, '0, 16'd65532);
		send_word(CMD_ALLOC, '0, 16'd65535);

		// random phases: optional policy change and table refill, then bursts
		burst_left = 0;
		while (words_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
			drain_and_settle();
			if ($urandom_range(0, 1)) write_mode(1'($urandom_range(0, 1)));
			if ($urandom_range(0, 2) == 0) begin
				for (s = 0; s < NBLK; s++) load_random_capacity(SLOT_W'(s));
			end
			phase_len = $urandom_range(30, 90);
			for (k = 0; k < phase_len; k++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					sender_gap($urandom_range(0, 12));
				end
				burst_left--;
				send_random();
			end
		end

		drain_and_settle();
		$display("run covered %0d words: %0d capacity loads, %0d requests (%0d granted, %0d no fit)",
			words_sent, ledger.loads, ledger.requests, ledger.grants, ledger.misses);
		$display("placement policy written %0d times across first fit and best fit", mode_writes);
		if (ledger.bad == 0 && ledger.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d bad result words, %0d expected result words never arrived",
				ledger.bad, ledger.pending());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
